FILE: src/swhl_pkg.sv
// Shared types and constants for the sliding-window high/low channel.
package swhl_pkg;

    localparam int PRICE_W          = 32;
    localparam int MID_W            = PRICE_W + 1;
    localparam int WLEN_W           = 7;
    localparam int MAX_WINDOW_DEF   = 64;
    localparam int APB_ADDR_W       = 2;
    localparam int APB_DATA_W       = 32;

    localparam logic [APB_ADDR_W-1:0] REG_WINDOW_LENGTH = '0;
    localparam logic [WLEN_W-1:0]     WLEN_RESET        = WLEN_W'(20);

    typedef struct packed {
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] low_price;
        logic               series_start;
    } swhl_in_t;

    typedef struct packed {
        logic [PRICE_W-1:0] channel_high;
        logic [PRICE_W-1:0] channel_low;
        logic [MID_W-1:0]   channel_mid;
        logic               result_valid;
    } swhl_out_t;

    // one stored bar, shifted cell to cell on each accepted item
    typedef struct packed {
        logic [PRICE_W-1:0] hi;
        logic [PRICE_W-1:0] lo;
    } swhl_bar_t;

    // running extremes walking down the chain behind a token
    typedef struct packed {
        logic               tok;
        logic [PRICE_W-1:0] hi;
        logic [PRICE_W-1:0] lo;
    } swhl_scan_t;

endpackage

FILE: src/sliding_window_high_low_channel.sv
// The scan token leaves the launch register, walks every cell, and its result is registered.
// One item at a time: a new item is accepted only once the last scan has been captured.
// A waiting result does not block acceptance; a stalled scan holds at the chain's tail.
// Reset (rst_n, async low): fill count zero, window_length 20, no item in flight.
// Bar history in the cells is not reset; cells never written are outside the window.
module sliding_window_high_low_channel #(
    parameter int MAX_WINDOW = swhl_pkg::MAX_WINDOW_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input item channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  swhl_pkg::swhl_in_t                  in_data,
    // result item channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output swhl_pkg::swhl_out_t                 out_data,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swhl_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [swhl_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [swhl_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import swhl_pkg::*;

    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (LW > WLEN_W) ? LW : WLEN_W;
    localparam logic [CW-1:0] MAXW_C = CW'(MAX_WINDOW);
    localparam logic [LW-1:0] MAXW_L = LW'(MAX_WINDOW);

    // ---------------- configuration ----------------
    logic [WLEN_W-1:0] wlen_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_WINDOW_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WLEN_RESET;
        end
        else if (cfg_wr)
        begin
            wlen_reg <= pwdata[WLEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_WINDOW_LENGTH)
        begin
            prdata[WLEN_W-1:0] = wlen_reg;
        end
    end

    // effective length: clamp to the chain depth
    logic [CW-1:0] wlen_ext;
    logic [LW-1:0] len_eff;

    assign wlen_ext = CW'(wlen_reg);
    assign len_eff  = (wlen_ext > MAXW_C) ? MAXW_L : wlen_ext[LW-1:0];

    // ---------------- control ----------------
    logic          accept;
    logic          step;
    logic          capture;
    logic          busy_reg;
    logic          launch_reg;
    logic          win_ok_reg, win_ok_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic          out_valid_reg;
    swhl_out_t     out_data_reg;

    swhl_bar_t     bar_w  [0:MAX_WINDOW];
    swhl_scan_t    scan_w [0:MAX_WINDOW];

    // one item in flight; the next is taken once its scan leaves the chain
    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;

    // freeze the scan while its finished result cannot be parked
    assign step    = !(scan_w[MAX_WINDOW].tok && out_valid_reg && !out_ready);
    assign capture = scan_w[MAX_WINDOW].tok && step;

    // fill count saturates at chain depth; series start restarts at one bar
    always_comb
    begin
        if (in_data.series_start)
        begin
            fill_next = LW'(1);
        end
        else if (fill_reg == MAXW_L)
        begin
            fill_next = fill_reg;
        end
        else
        begin
            fill_next = fill_reg + LW'(1);
        end
        win_ok_next = (len_eff != '0) && (fill_next >= len_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            launch_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                fill_reg <= fill_next;
            end
            else if (capture)
            begin
                busy_reg <= 1'b0;
            end
            if (accept)
            begin
                launch_reg <= 1'b1;
            end
            else if (step)
            begin
                launch_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_ok_reg <= win_ok_next;
        end
    end

    // ---------------- cell chain ----------------
    // cell k holds the bar k items old; new bar enters cell 0
    assign bar_w[0].hi = in_data.high_price;
    assign bar_w[0].lo = in_data.low_price;

    // scan starts at neutral extremes; cell 0 always lies in a nonempty window
    assign scan_w[0].tok = launch_reg;
    assign scan_w[0].hi  = '0;
    assign scan_w[0].lo  = '1;

    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        swhl_cell #(
            .MAX_WINDOW (MAX_WINDOW),
            .IDX        (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (accept),
            .step     (step),
            .len      (len_eff),
            .bar_in   (bar_w[k]),
            .bar_out  (bar_w[k+1]),
            .scan_in  (scan_w[k]),
            .scan_out (scan_w[k+1])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (capture)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            if (win_ok_reg)
            begin
                out_data_reg.channel_high <= scan_w[MAX_WINDOW].hi;
                out_data_reg.channel_low  <= scan_w[MAX_WINDOW].lo;
                out_data_reg.channel_mid  <= MID_W'(scan_w[MAX_WINDOW].hi)
                                           + MID_W'(scan_w[MAX_WINDOW].lo);
                out_data_reg.result_valid <= 1'b1;
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: src/swhl_cell.sv
// One window cell: holds a bar and folds it into the passing scan.
module swhl_cell #(
    parameter int MAX_WINDOW = swhl_pkg::MAX_WINDOW_DEF,
    parameter int IDX        = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                shift,
    input  logic                                step,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]     len,
    input  swhl_pkg::swhl_bar_t                 bar_in,
    output swhl_pkg::swhl_bar_t                 bar_out,
    input  swhl_pkg::swhl_scan_t                scan_in,
    output swhl_pkg::swhl_scan_t                scan_out
);
    import swhl_pkg::*;

    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam logic [LW-1:0] MY_IDX = LW'(IDX);

    swhl_bar_t  bar_reg;
    logic       tok_reg;
    logic       tok_next;
    logic [PRICE_W-1:0] hi_reg, hi_next;
    logic [PRICE_W-1:0] lo_reg, lo_next;
    logic       take;

    // cell lies inside the window when its age is below the length
    assign take = scan_in.tok && (MY_IDX < len);

    always_comb
    begin
        tok_next = scan_in.tok;
        hi_next  = scan_in.hi;
        lo_next  = scan_in.lo;
        if (take)
        begin
            if (bar_reg.hi > scan_in.hi)
            begin
                hi_next = bar_reg.hi;
            end
            if (bar_reg.lo < scan_in.lo)
            begin
                lo_next = bar_reg.lo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            bar_reg <= bar_in;
        end
        if (step)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else if (step)
        begin
            tok_reg <= tok_next;
        end
    end

    assign bar_out      = bar_reg;
    assign scan_out.tok = tok_reg;
    assign scan_out.hi  = hi_reg;
    assign scan_out.lo  = lo_reg;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the sliding-window high/low channel block.
module tb;
    import swhl_pkg::*;

    localparam int MAX_WIN   = MAX_WINDOW_DEF;
    // slowest item: longest send gap + full chain scan + longest result stall;
    // the limit covers every item that slow several times over
    localparam int CYCLE_LIMIT = 1_500_000;

    // Price-channel predictor and the queue of channel results still owed by the block.
    class channel_scoreboard;
        localparam int DEPTH = MAX_WINDOW_DEF;

        swhl_out_t          owed_q[$];
        logic [PRICE_W-1:0] high_hist[DEPTH];
        logic [PRICE_W-1:0] low_hist[DEPTH];
        int unsigned        fill_count;
        int unsigned        write_pos;
        int unsigned        window_len;
        int unsigned        results_seen;
        int                 errors;

        function new();
            fill_count   = 0;
            write_pos    = 0;
            window_len   = WLEN_RESET;
            results_seen = 0;
            errors       = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endfunction

        // Push one bar into the history and work out the channel it yields.
        function void note_bar(swhl_in_t bar);
            swhl_out_t          res;
            int unsigned        span;
            int unsigned        idx;
            logic [PRICE_W-1:0] top;
            logic [PRICE_W-1:0] bottom;
            if (bar.series_start)
            begin
                fill_count = 0;
                write_pos  = 0;
            end
            high_hist[write_pos] = bar.high_price;
            low_hist[write_pos]  = bar.low_price;
            write_pos = (write_pos + 1) % DEPTH;
            if (fill_count < DEPTH)
                fill_count++;
            span = (window_len > DEPTH) ? DEPTH : window_len;
            res  = '0;
            if (span != 0 && fill_count >= span)
            begin
                top    = bar.high_price;
                bottom = bar.low_price;
                for (int k = 1; k < span; k++)
                begin
                    idx = (write_pos + DEPTH - 1 - k) % DEPTH;
                    if (high_hist[idx] > top)
                        top = high_hist[idx];
                    if (low_hist[idx] < bottom)
                        bottom = low_hist[idx];
                end
                res.channel_high = top;
                res.channel_low  = bottom;
                res.channel_mid  = {1'b0, top} + {1'b0, bottom};
                res.result_valid = 1'b1;
            end
            owed_q = {owed_q, res};
        endfunction

        function void check_result(swhl_out_t got);
            swhl_out_t want;
            results_seen++;
            if (owed_q.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing owed", results_seen));
                return;
            end
            want = owed_q.pop_front();
            if (got.channel_high !== want.channel_high)
                report($sformatf("result %0d channel_high %h, want %h",
                                 results_seen, got.channel_high, want.channel_high));
            if (got.channel_low !== want.channel_low)
                report($sformatf("result %0d channel_low %h, want %h",
                                 results_seen, got.channel_low, want.channel_low));
            if (got.channel_mid !== want.channel_mid)
                report($sformatf("result %0d channel_mid %h, want %h",
                                 results_seen, got.channel_mid, want.channel_mid));
            if (got.result_valid !== want.result_valid)
                report($sformatf("result %0d result_valid %b, want %b",
                                 results_seen, got.result_valid, want.result_valid));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    swhl_in_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    swhl_out_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    channel_scoreboard sb;
    int unsigned       cycle_count = 0;
    bit                no_idle = 0;       // phase-wide switch: no gaps, no stalls
    logic [PRICE_W-1:0] price_level;      // center of the random price walk

    sliding_window_high_low_channel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("sliding_window_high_low_channel test failed");
        $finish;
    end

    // Monitor. Everything is driven on the falling edge, so values seen at the
    // rising edge are settled. The result check runs before the new bar is noted;
    // a result taken at the same edge as a bar always belongs to an earlier bar.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (in_valid && in_ready)
                sb.note_bar(in_data);
        end
    end

    // Idle length: drawn from a short, a middle or a long range; the short range is the most likely.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 93)
            return $urandom_range(4, 10);
        return $urandom_range(20, 70);
    endfunction

    // Result side: ready drops for random stretches unless the phase runs flat out.
    initial
    begin : result_sink
        int unsigned stall;
        stall     = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0 && !no_idle)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall = 0;
                if (!no_idle && $urandom_range(0, 5) == 0)
                    stall = idle_len();
            end
        end
    end

    function automatic swhl_in_t mk_bar(logic [PRICE_W-1:0] hi, logic [PRICE_W-1:0] lo,
                                        logic start);
        swhl_in_t b;
        b.high_price   = hi;
        b.low_price    = lo;
        b.series_start = start;
        return b;
    endfunction

    // Random bar: mostly a price walk with high above low, plus raw random words,
    // the price extremes, and inverted bars (low above high).
    function automatic swhl_in_t rand_bar();
        logic [PRICE_W-1:0] corner[4];
        int unsigned        r;
        swhl_in_t           b;
        corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE};
        r = $urandom_range(0, 99);
        b.series_start = 1'b0;
        price_level = price_level + $urandom_range(0, 4095) - 2048;
        if (r < 60)
        begin
            b.high_price = price_level + $urandom_range(0, 1023);
            b.low_price  = price_level - $urandom_range(0, 1023);
        end
        else if (r < 80)
        begin
            b.high_price = $urandom;
            b.low_price  = $urandom;
        end
        else if (r < 90)
        begin
            b.high_price = corner[$urandom_range(0, 3)];
            b.low_price  = corner[$urandom_range(0, 3)];
        end
        else
        begin
            b.high_price = price_level - $urandom_range(0, 500);
            b.low_price  = price_level + $urandom_range(1, 500);
        end
        return b;
    endfunction

    // Present one item and hold it until it is taken. Valid stays up across
    // back-to-back items; a gap lowers it on its own falling edge.
    task automatic send_bar(swhl_in_t bar);
        int unsigned gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= bar;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop sending, wait for every owed result, then let the scan chain run dry.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (MAX_WIN + 8) @(posedge clk);
    endtask

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_xfer(logic wr, logic [APB_ADDR_W-1:0] addr,
                            logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_window_length();
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b0, REG_WINDOW_LENGTH, '0, rd);
        if (rd !== APB_DATA_W'(sb.window_len))
            sb.report($sformatf("window_length reads %0d, want %0d", rd, sb.window_len));
    endtask

    // Only called with the block idle. Upper data bits carry junk; the
    // register keeps its low 7 bits only.
    task automatic set_window_length(logic [WLEN_W-1:0] len);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b1, REG_WINDOW_LENGTH,
                 {(APB_DATA_W - WLEN_W)'($urandom_range(0, (1 << (APB_DATA_W - WLEN_W)) - 1)),
                  len}, rd);
        sb.window_len = len;
        check_window_length();
    endtask

    // Random phase: mostly whole series that run past the window with random
    // prices, some cut short before the window fills, and stray series starts.
    task automatic run_phase(int unsigned n_items, int unsigned len);
        int unsigned eff;
        int unsigned left;
        int unsigned series_len;
        swhl_in_t    b;
        eff  = (len > MAX_WIN) ? MAX_WIN : len;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(0, 4) != 0)
                series_len = eff + $urandom_range(0, eff + 8);
            else
                series_len = $urandom_range(1, eff + 1);
            if (series_len == 0)
                series_len = 1;
            if (series_len > left)
                series_len = left;
            price_level = $urandom;
            for (int i = 0; i < series_len; i++)
            begin
                b = rand_bar();
                b.series_start = (i == 0) || ($urandom_range(0, 99) == 0);
                send_bar(b);
            end
            left -= series_len;
        end
    endtask

    initial
    begin : main
        int unsigned lengths[13];
        sb = new();
        lengths = '{64, 3, 127, 1, 0, 10, 65, 2, 40, 7, 64, 5, 20};
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // register comes out of reset at its default length
        check_window_length();

        // Window of one: every bar is its own channel. Price extremes, full-scale
        // midpoint, inverted bar, alternating bit patterns.
        set_window_length(1);
        send_bar(mk_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_bar(mk_bar(32'h0000_0000, 32'h0000_0000, 1'b0));
        send_bar(mk_bar(32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
        send_bar(mk_bar(32'hAAAA_AAAA, 32'h5555_5555, 1'b0));
        send_bar(mk_bar(32'h5555_5555, 32'hAAAA_AAAA, 1'b1));
        wait_idle();

        // Zero length: never valid, all fields zero.
        set_window_length(0);
        send_bar(mk_bar(32'h1234_5678, 32'h0000_1234, 1'b1));
        send_bar(mk_bar(32'hFFFF_FFFF, 32'h0000_0000, 1'b0));
        send_bar(mk_bar(32'h8000_0000, 32'h8000_0000, 1'b0));
        wait_idle();

        // Window of three: filling, full, sliding past an extreme, inverted bar,
        // then a new series mid-stream that must drop the old history.
        set_window_length(3);
        send_bar(mk_bar(32'h0001_0000, 32'h0000_8000, 1'b1));
        send_bar(mk_bar(32'h0002_0000, 32'h0000_5000, 1'b0));
        send_bar(mk_bar(32'h0001_5000, 32'h0000_9000, 1'b0));
        send_bar(mk_bar(32'hFFFF_FFFF, 32'h0000_0001, 1'b0));
        send_bar(mk_bar(32'h0000_0000, 32'h0000_0000, 1'b0));
        send_bar(mk_bar(32'h0000_0007, 32'h0000_0009, 1'b0));
        send_bar(mk_bar(32'h0000_0100, 32'h0000_0050, 1'b1));
        send_bar(mk_bar(32'h0000_0200, 32'h0000_0020, 1'b0));
        send_bar(mk_bar(32'h0000_0300, 32'h0000_0010, 1'b0));
        wait_idle();

        // Length beyond the history depth behaves as the full depth.
        set_window_length(100);
        send_bar(mk_bar(32'h0000_0001, 32'h0000_0000, 1'b1));
        send_bar(mk_bar(32'h0000_0002, 32'h0000_0001, 1'b0));
        wait_idle();

        // Random phases over a spread of lengths; long windows get more bars so
        // that full windows show up often enough.
        foreach (lengths[p])
        begin
            set_window_length(WLEN_W'(lengths[p]));
            no_idle = ($urandom_range(0, 3) == 0);
            run_phase((lengths[p] >= 32) ? 200 : 70, lengths[p]);
            wait_idle();
            no_idle = 1'b0;
        end

        if (sb.owed_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.owed_q.size()));
        if (sb.errors == 0)
            $display("sliding_window_high_low_channel test passed");
        else
            $display("sliding_window_high_low_channel test failed");
        $finish;
    end

endmodule
